// File: hdl/mfr_pkg.sv
// shared constants and types for the marker frame receiver
package mfr_pkg;

  localparam int FRAME_DEPTH = 64;
  localparam int IDX_W       = $clog2(FRAME_DEPTH);
  localparam int FILL_W      = $clog2(FRAME_DEPTH + 1);
  localparam int BANKS       = 2;
  localparam int BANK_W      = $clog2(BANKS);
  localparam int CNT_W       = $clog2(BANKS + 1);
  localparam int RAM_DEPTH   = BANKS * (2 ** IDX_W);
  localparam int RAM_AW      = BANK_W + IDX_W;
  localparam int BYTE_W      = 8;
  localparam int OUT_IDX_W   = 6;
  localparam int MARKER_W    = 16;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [MARKER_W-1:0] START_MARKER_RST = 16'h5354;
  localparam logic [MARKER_W-1:0] END_MARKER_RST   = 16'h4544;
  localparam logic [1:0]          HIST_FULL        = 2'd3;

  typedef enum logic {
    REG_START_MARKER = 1'b0,
    REG_END_MARKER   = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [FILL_W-1:0]   len;
    logic [MARKER_W-1:0] head;
  } frame_cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [BANK_W-1:0] wr_bank;
    logic [BANK_W-1:0] rd_bank;
  } fifo_status_t;

endpackage

// File: hdl/mfr_ram.sv
// generic single-write, registered-read ram
module mfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/mfr_cmd_fifo.sv
// two-entry queue of completed frames, one per store bank
module mfr_cmd_fifo import mfr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  frame_cmd_t   push_cmd,
  input  logic         pop,
  output frame_cmd_t   head_cmd,
  output fifo_status_t status
);

  frame_cmd_t        entries [BANKS];
  logic [BANK_W-1:0] wr_ptr;
  logic [BANK_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;

  assign head_cmd       = entries[rd_ptr];
  assign status.full    = (count == CNT_W'(BANKS));
  assign status.empty   = (count == '0);
  assign status.wr_bank = wr_ptr;
  assign status.rd_bank = rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full) else $error("frame pushed with both banks taken");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty) else $error("frame released with none pending");

endmodule

// File: hdl/mfr_front.sv
// receive side: byte history, marker detection and frame storage
module mfr_front import mfr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [BYTE_W-1:0]   rx_byte,
  input  logic [MARKER_W-1:0] start_marker,
  input  logic [MARKER_W-1:0] end_marker,
  input  logic [BANK_W-1:0]   wr_bank,
  output logic                ram_we,
  output logic [RAM_AW-1:0]   ram_waddr,
  output logic [BYTE_W-1:0]   ram_wdata,
  output logic                cmd_push,
  output frame_cmd_t          cmd
);

  logic [BYTE_W-1:0]   hist_old;
  logic [BYTE_W-1:0]   hist_prev;
  logic [1:0]          hist_cnt;
  logic                in_frame;
  logic [FILL_W-1:0]   fill;
  logic [MARKER_W-1:0] head;

  logic                open_frame;
  logic                active;
  logic                close_frame;
  logic                overflow;
  logic [FILL_W-1:0]   wr_idx;
  logic [FILL_W-1:0]   fill_next;
  logic [MARKER_W-1:0] head_next;

  always_comb begin
    open_frame  = (hist_cnt >= 2'd2) && !in_frame &&
                  (hist_old == start_marker[15:8]) && (hist_prev == start_marker[7:0]);
    active      = in_frame || open_frame;
    // marker bytes travel with the command, the store holds the rest
    wr_idx      = open_frame ? FILL_W'(2) : fill;
    fill_next   = wr_idx + 1'b1;
    close_frame = active && (hist_prev == end_marker[15:8]) && (rx_byte == end_marker[7:0]);
    overflow    = active && !close_frame && (fill_next >= FILL_W'(FRAME_DEPTH));
    head_next   = open_frame ? {hist_old, hist_prev} : head;
  end

  assign ram_we    = accept && active;
  assign ram_waddr = {wr_bank, wr_idx[IDX_W-1:0]};
  assign ram_wdata = rx_byte;
  assign cmd_push  = accept && close_frame;
  assign cmd.len   = fill_next;
  assign cmd.head  = head_next;

  always_ff @(posedge clk) begin
    if (accept) begin
      head <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_old  <= '0;
      hist_prev <= '0;
      hist_cnt  <= '0;
      in_frame  <= 1'b0;
      fill      <= '0;
    end else if (accept) begin
      if (overflow) begin
        // dropped frame also forgets the history
        in_frame  <= 1'b0;
        fill      <= '0;
        hist_cnt  <= '0;
        hist_old  <= '0;
        hist_prev <= '0;
      end else begin
        hist_old  <= hist_prev;
        hist_prev <= rx_byte;
        if (close_frame) begin
          in_frame <= 1'b0;
          fill     <= '0;
          hist_cnt <= '0;
        end else begin
          if (hist_cnt != HIST_FULL) begin
            hist_cnt <= hist_cnt + 1'b1;
          end
          if (active) begin
            in_frame <= 1'b1;
            fill     <= fill_next;
          end
        end
      end
    end
  end

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (fill >= FILL_W'(3)) && (fill < FILL_W'(FRAME_DEPTH)))
    else $error("fill count out of range inside a frame");

  a_fill_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (fill == '0)) else $error("fill count left over while idle");

endmodule

// File: hdl/mfr_back.sv
// readout side: walks a completed frame and presents it byte by byte
module mfr_back import mfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  frame_cmd_t           cmd,
  input  logic                 cmd_empty,
  input  logic [BANK_W-1:0]    rd_bank,
  input  logic [BYTE_W-1:0]    ram_rdata,
  output logic                 ram_re,
  output logic [RAM_AW-1:0]    ram_raddr,
  output logic                 cmd_pop,
  input  logic                 pop,
  output logic                 empty,
  output logic [BYTE_W-1:0]    frame_byte,
  output logic [OUT_IDX_W-1:0] byte_index,
  output logic                 last_byte
);

  logic [IDX_W-1:0]  rd_idx;
  logic              pend_valid;
  logic              pend_head;
  logic [BYTE_W-1:0] pend_byte;
  logic [IDX_W-1:0]  pend_idx;
  logic              pend_last;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic [IDX_W-1:0]  out_idx;
  logic              out_last;

  logic              issue;
  logic              is_last;
  logic              sel_head;
  logic [BYTE_W-1:0] head_byte;

  always_comb begin
    issue     = !cmd_empty && !pend_valid && (!out_valid || pop);
    is_last   = ((FILL_W'(rd_idx) + 1'b1) == cmd.len);
    sel_head  = (rd_idx == IDX_W'(0)) || (rd_idx == IDX_W'(1));
    head_byte = rd_idx[0] ? cmd.head[7:0] : cmd.head[15:8];
  end

  assign ram_re     = issue && !sel_head;
  assign ram_raddr  = {rd_bank, rd_idx};
  assign cmd_pop    = issue && is_last;
  assign empty      = !out_valid;
  assign frame_byte = out_byte;
  assign byte_index = OUT_IDX_W'(out_idx);
  assign last_byte  = out_last;

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_head <= sel_head;
      pend_byte <= head_byte;
      pend_idx  <= rd_idx;
      pend_last <= is_last;
    end
    if (pend_valid) begin
      out_byte <= pend_head ? pend_byte : ram_rdata;
      out_idx  <= pend_idx;
      out_last <= pend_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pend_valid <= issue;
      if (issue) begin
        rd_idx <= is_last ? '0 : rd_idx + 1'b1;
      end
      if (pend_valid) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pend_finds_room: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !out_valid) else $error("read returned with output register busy");

  a_pend_lands: assert property (@(posedge clk) disable iff (rst)
    pend_valid |=> out_valid) else $error("read data lost before output register");

endmodule

// File: hdl/marker_frame_receiver_core.sv
// top level of the marker frame receiver: config registers and wiring
// Receives one byte per accepted push. A frame opens when the two bytes before the current
// one match start_marker, and closes when the previous and current bytes match end_marker;
// the whole frame, marker bytes included, then appears on the result queue one byte per
// transaction, byte_index counting from zero and last_byte set on the final byte. The frame
// store is a two-bank ram read through a registered port. Each byte, the first two taken
// from the command and the rest read from the store, passes through a pending register to
// the output register, and a new read is issued only when none is pending and the output
// register is empty or being popped. One completed frame may await readout while the next is
// received; once a second frame closes both banks are taken and full stays high until the
// last byte of the older frame has been read from the store. A frame reaching FRAME_DEPTH
// bytes without a close is discarded with no results. No clearing pass is needed after reset.
module marker_frame_receiver_core import mfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  input  logic                 push,
  output logic                 full,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [BYTE_W-1:0]    frame_byte,
  output logic [OUT_IDX_W-1:0] byte_index,
  output logic                 last_byte
);

  logic [MARKER_W-1:0] start_marker;
  logic [MARKER_W-1:0] end_marker;
  reg_sel_t            reg_sel;
  logic                cfg_write;

  logic                accept;
  logic                pop_ok;
  fifo_status_t        fifo_status;
  frame_cmd_t          push_cmd;
  frame_cmd_t          head_cmd;
  logic                cmd_push;
  logic                cmd_pop;
  logic                ram_we;
  logic [RAM_AW-1:0]   ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [RAM_AW-1:0]   ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  assign pready    = 1'b1;
  assign reg_sel   = reg_sel_t'(paddr[PADDR_W-1]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_START_MARKER: prdata = PDATA_W'(start_marker);
      REG_END_MARKER:   prdata = PDATA_W'(end_marker);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_START_MARKER: start_marker <= pwdata[MARKER_W-1:0];
        REG_END_MARKER:   end_marker   <= pwdata[MARKER_W-1:0];
        default:          start_marker <= start_marker;
      endcase
    end
  end

  assign full   = fifo_status.full;
  assign accept = push && !full;
  assign pop_ok = pop && !empty;

  mfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (rx_byte),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .wr_bank      (fifo_status.wr_bank),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .cmd_push     (cmd_push),
    .cmd          (push_cmd)
  );

  mfr_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .status   (fifo_status)
  );

  mfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (head_cmd),
    .cmd_empty  (fifo_status.empty),
    .rd_bank    (fifo_status.rd_bank),
    .ram_rdata  (ram_rdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .cmd_pop    (cmd_pop),
    .pop        (pop_ok),
    .empty      (empty),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last_byte  (last_byte)
  );

endmodule
